// ----- src/hhgs_pkg.sv -----
// Shared types, constants and helpers for the hall hold gesture sequencer.
package hhgs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_COUNT = 2'd3;

  localparam logic [14:0] COOLDOWN_RST    = 15'd1000;
  localparam logic [15:0] READY_DELAY_RST = 16'd5000;
  localparam logic [14:0] BLINK_RST       = 15'd300;
  localparam logic [7:0]  BLINK_COUNT_RST = 8'd10;

  localparam logic [7:0] FULL_LEVEL = 8'hFE;
  localparam logic [7:0] ORANGE_G   = 8'hA5;
  localparam logic [7:0] COLOR_MAX  = 8'hFF;
  localparam logic [7:0] COLOR_OFF  = 8'h00;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MEDIUM  = 2'd2,
    CMD_LONG    = 2'd3
  } cmd_t;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_TOGGLE = 3'd1;
  localparam logic [2:0] ACT_STATUS = 3'd2;
  localparam logic [2:0] ACT_BIND   = 3'd3;
  localparam logic [2:0] ACT_LEAVE  = 3'd4;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_ARMED_1 = 9'b000000010,
    PH_ARMED_2 = 9'b000000100,
    PH_READY   = 9'b000001000,
    PH_LV_ON   = 9'b000010000,
    PH_LV_OFF  = 9'b000100000,
    PH_NS_OFF  = 9'b001000000,
    PH_NS_ON   = 9'b010000000,
    PH_LEAVE   = 9'b100000000
  } phase_t;

  localparam logic [3:0] PHN_IDLE    = 4'd0;
  localparam logic [3:0] PHN_ARMED_1 = 4'd1;
  localparam logic [3:0] PHN_ARMED_2 = 4'd2;
  localparam logic [3:0] PHN_READY   = 4'd3;
  localparam logic [3:0] PHN_LV_ON   = 4'd4;
  localparam logic [3:0] PHN_LV_OFF  = 4'd5;
  localparam logic [3:0] PHN_NS_OFF  = 4'd6;
  localparam logic [3:0] PHN_NS_ON   = 4'd7;
  localparam logic [3:0] PHN_LEAVE   = 4'd8;

  typedef struct packed {
    logic [14:0] cooldown_ms;
    logic [15:0] ready_delay_ms;
    logic [14:0] blink_ms;
    logic [7:0]  blink_count;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] lvl;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } led_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  blinks_left;
    logic [15:0] delay_left;
    logic        delay_armed;
    logic [15:0] cooldown_left;
    led_t        led;
  } st_t;

  function automatic logic [3:0] phase_num(phase_t p);
    logic [3:0] n;
    unique case (p)
      PH_IDLE:    n = PHN_IDLE;
      PH_ARMED_1: n = PHN_ARMED_1;
      PH_ARMED_2: n = PHN_ARMED_2;
      PH_READY:   n = PHN_READY;
      PH_LV_ON:   n = PHN_LV_ON;
      PH_LV_OFF:  n = PHN_LV_OFF;
      PH_NS_OFF:  n = PHN_NS_OFF;
      PH_NS_ON:   n = PHN_NS_ON;
      PH_LEAVE:   n = PHN_LEAVE;
      default:    n = PHN_IDLE;
    endcase
    return n;
  endfunction

endpackage

// ----- src/hhgs_in_if.sv -----
// Event request channel: command plus light and network status.
interface hhgs_in_if;
  import hhgs_pkg::*;

  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [7:0] light_level;
  logic       light_on;
  logic       joined;

  modport source (output valid, command, light_level, light_on, joined, input ready);
  modport sink   (input valid, command, light_level, light_on, joined, output ready);
endinterface

// ----- src/hhgs_out_if.sv -----
// Result request channel: action code, LED drive and phase.
interface hhgs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       led_enable;
  logic [7:0] led_level;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic [3:0] phase_now;

  modport source (output valid, action, led_enable, led_level, led_red, led_green,
                  led_blue, phase_now, input ready);
  modport sink   (input valid, action, led_enable, led_level, led_red, led_green,
                  led_blue, phase_now, output ready);
endinterface

// ----- src/hhgs_step.sv -----
// Next-state and action logic for one event of the gesture sequencer.
module hhgs_step (
  input  hhgs_pkg::st_t  st,
  input  hhgs_pkg::cfg_t cfg,
  input  hhgs_pkg::cmd_t command,
  input  logic [7:0]     light_level,
  input  logic           light_on,
  input  logic           joined,
  output hhgs_pkg::st_t  st_next,
  output logic [2:0]     action
);
  import hhgs_pkg::*;

  // Back to idle with the light's own look; in the leave phase only re-arm.
  function automatic st_t restore(st_t s, logic [7:0] lvl, logic on_i, logic [14:0] blink);
    st_t r;
    r = s;
    if (s.phase == PH_LEAVE) begin
      r.delay_left  = {1'b0, blink};
      r.delay_armed = 1'b1;
    end else begin
      r.delay_armed = 1'b0;
      r.led         = '{en: on_i, lvl: lvl, r: COLOR_MAX, g: COLOR_MAX, b: COLOR_MAX};
      r.phase       = PH_IDLE;
    end
    return r;
  endfunction

  always_comb begin
    st_t        ns;
    logic [2:0] act;
    logic       lit;
    ns  = st;
    act = ACT_NONE;
    lit = 1'b0;
    unique case (command)
      CMD_TICK: begin
        if (st.cooldown_left != 16'd0) begin
          ns.cooldown_left = st.cooldown_left - 16'd1;
        end
        if (st.delay_armed) begin
          if (st.delay_left[15:1] == 15'd0) begin
            ns.delay_left  = 16'd0;
            ns.delay_armed = 1'b0;
            unique case (st.phase)
              PH_ARMED_2: begin
                ns.phase       = PH_READY;
                ns.led         = '{en: 1'b1, lvl: FULL_LEVEL, r: COLOR_MAX, g: COLOR_OFF,
                                   b: COLOR_OFF};
                ns.delay_left  = {1'b0, cfg.ready_delay_ms[15:1]};
                ns.delay_armed = 1'b1;
              end
              PH_READY: begin
                ns.phase       = PH_LV_ON;
                ns.blinks_left = cfg.blink_count;
                ns.led         = '{en: 1'b0, lvl: FULL_LEVEL, r: COLOR_MAX, g: COLOR_OFF,
                                   b: COLOR_OFF};
                ns.delay_left  = {1'b0, cfg.blink_ms};
                ns.delay_armed = 1'b1;
              end
              PH_LV_ON, PH_LV_OFF: begin
                if (st.blinks_left != 8'd0) begin
                  lit            = (st.phase == PH_LV_ON);
                  ns.phase       = lit ? PH_LV_OFF : PH_LV_ON;
                  ns.blinks_left = st.blinks_left - 8'd1;
                  ns.led         = '{en: lit, lvl: FULL_LEVEL, r: COLOR_MAX, g: COLOR_OFF,
                                     b: COLOR_OFF};
                end else begin
                  // green pause before the leave request
                  ns.phase = PH_LEAVE;
                  ns.led   = '{en: 1'b1, lvl: FULL_LEVEL, r: COLOR_OFF, g: COLOR_MAX,
                               b: COLOR_OFF};
                  ns.delay_left = {cfg.blink_ms, 1'b0};
                end
                ns.delay_armed = 1'b1;
                if (st.blinks_left != 8'd0) begin
                  ns.delay_left = {1'b0, cfg.blink_ms};
                end
              end
              PH_LEAVE: begin
                act              = ACT_LEAVE;
                ns.phase         = PH_IDLE;
                ns.cooldown_left = {cfg.cooldown_ms, 1'b0};
                ns               = restore(ns, light_level, light_on, cfg.blink_ms);
              end
              PH_NS_OFF, PH_NS_ON: begin
                if (st.blinks_left != 8'd0) begin
                  lit            = (st.phase == PH_NS_ON);
                  ns.phase       = lit ? PH_NS_OFF : PH_NS_ON;
                  ns.blinks_left = st.blinks_left - 8'd1;
                  ns.led         = joined ?
                    '{en: lit, lvl: FULL_LEVEL, r: COLOR_OFF, g: COLOR_MAX, b: COLOR_OFF} :
                    '{en: lit, lvl: FULL_LEVEL, r: COLOR_MAX, g: COLOR_OFF, b: COLOR_OFF};
                  ns.delay_left  = {3'b000, cfg.blink_ms[14:2]};
                  ns.delay_armed = 1'b1;
                end else begin
                  ns               = restore(ns, light_level, light_on, cfg.blink_ms);
                  ns.cooldown_left = {1'b0, cfg.cooldown_ms};
                end
              end
              default: begin
                ns = restore(ns, light_level, light_on, cfg.blink_ms);
              end
            endcase
          end else begin
            ns.delay_left = st.delay_left - 16'd1;
          end
        end
      end
      CMD_RELEASE: begin
        if (st.phase == PH_IDLE) begin
          if (st.cooldown_left == 16'd0) begin
            ns.cooldown_left = {1'b0, cfg.cooldown_ms};
            act              = ACT_TOGGLE;
          end
          ns = restore(ns, light_level, light_on, cfg.blink_ms);
        end else if (st.phase == PH_ARMED_1) begin
          act            = ACT_STATUS;
          ns.phase       = PH_NS_OFF;
          ns.blinks_left = cfg.blink_count;
          ns.delay_left  = {1'b0, cfg.blink_ms};
          ns.delay_armed = 1'b1;
        end else begin
          if (st.phase == PH_ARMED_2) begin
            act = ACT_BIND;
          end
          ns = restore(ns, light_level, light_on, cfg.blink_ms);
        end
      end
      CMD_MEDIUM: begin
        if (st.phase == PH_IDLE) begin
          ns.phase = PH_ARMED_1;
          ns.led   = '{en: 1'b1, lvl: FULL_LEVEL, r: COLOR_OFF, g: COLOR_MAX, b: COLOR_OFF};
        end else begin
          ns = restore(ns, light_level, light_on, cfg.blink_ms);
        end
      end
      CMD_LONG: begin
        if (st.phase == PH_ARMED_1) begin
          ns.phase       = PH_ARMED_2;
          ns.led         = '{en: 1'b1, lvl: FULL_LEVEL, r: COLOR_MAX, g: ORANGE_G,
                             b: COLOR_OFF};
          ns.delay_left  = cfg.ready_delay_ms;
          ns.delay_armed = 1'b1;
        end else begin
          ns = restore(ns, light_level, light_on, cfg.blink_ms);
        end
      end
      default: begin
        ns = st;
      end
    endcase
    st_next = ns;
    action  = act;
  end

endmodule

// ----- src/hall_hold_gesture_sequencer_core.sv -----
// Top level of the hall hold gesture sequencer: state, config and result register.
// A result is registered and is valid in the cycle after its event request is accepted.
// Throughput: one event per cycle; a new request is taken while the result waits
// as long as the result is taken in the same cycle.
// Reset (synchronous, rst high): phase idle, timers and counts zero, LED off,
// config registers back to their defaults, result register empty.
module hall_hold_gesture_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [hhgs_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [hhgs_pkg::CFG_DATA_W-1:0]     write_data,
  hhgs_in_if.sink                             evt,
  hhgs_out_if.source                          res
);
  import hhgs_pkg::*;

  cfg_t       cfg;
  st_t        st;
  st_t        st_next;
  logic [2:0] action_next;
  logic       accept;

  assign evt.ready = !res.valid || res.ready;
  assign accept    = evt.valid && evt.ready;

  hhgs_step u_step (
    .st          (st),
    .cfg         (cfg),
    .command     (evt.command),
    .light_level (evt.light_level),
    .light_on    (evt.light_on),
    .joined      (evt.joined),
    .st_next     (st_next),
    .action      (action_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cooldown_ms: COOLDOWN_RST, ready_delay_ms: READY_DELAY_RST,
               blink_ms: BLINK_RST, blink_count: BLINK_COUNT_RST};
    end else if (write_enable) begin
      unique case (reg_index)
        CFG_COOLDOWN:    cfg.cooldown_ms    <= write_data[14:0];
        CFG_READY_DELAY: cfg.ready_delay_ms <= write_data;
        CFG_BLINK:       cfg.blink_ms       <= write_data[14:0];
        CFG_BLINK_COUNT: cfg.blink_count    <= write_data[7:0];
        default:         cfg                <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, blinks_left: 8'd0, delay_left: 16'd0, delay_armed: 1'b0,
              cooldown_left: 16'd0, led: '0};
      res.valid <= 1'b0;
    end else if (accept) begin
      st        <= st_next;
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.action     <= action_next;
      res.led_enable <= st_next.led.en;
      res.led_level  <= st_next.led.lvl;
      res.led_red    <= st_next.led.r;
      res.led_green  <= st_next.led.g;
      res.led_blue   <= st_next.led.b;
      res.phase_now  <= phase_num(st_next.phase);
    end
  end

  // timer is armed exactly in the timed phases
  assert property (@(posedge clk) disable iff (rst)
    ((st.phase == PH_IDLE) || (st.phase == PH_ARMED_1)) == !st.delay_armed)
    else $error("delay timer armed state disagrees with phase");

  // toggle only when the cooldown had run out
  assert property (@(posedge clk) disable iff (rst)
    accept && (evt.command == CMD_RELEASE) && (st.cooldown_left != 16'd0)
    |=> res.action != ACT_TOGGLE)
    else $error("light toggle during cooldown");

  // a leave request always lands back in idle
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.action == ACT_LEAVE) |-> res.phase_now == PHN_IDLE)
    else $error("leave result not in idle phase");

  // an empty result register never blocks requests
  assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> evt.ready)
    else $error("request stalled with empty result register");

endmodule

// ----- dv/hhgs_checker.sv -----
// Scoreboard for the hall hold gesture sequencer: mirrors the event rules and checks each result.
module hhgs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [hhgs_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [hhgs_pkg::CFG_DATA_W-1:0] write_data,
  hhgs_in_if                              evt,
  hhgs_out_if                             res,
  output int                              fail_count,
  output int                              n_pending
);
  import hhgs_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    led_t       led;
    logic [3:0] phase;
  } outcome_t;

  cfg_t        cfg;
  logic [3:0]  ph;
  logic [7:0]  blinks_left;
  logic [15:0] timer_left;
  logic        timer_armed;
  logic [15:0] cool_left;
  led_t        led;
  outcome_t    expected_outcomes[$];
  int          errors = 0;

  assign fail_count = errors;

  function automatic led_t lamp(logic en, logic [7:0] lvl, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
    return {en, lvl, r, g, b};
  endfunction

  function automatic void arm_timer(logic [15:0] d);
    timer_left  = d;
    timer_armed = 1'b1;
  endfunction

  // in the leave pause this only restarts the timer
  function automatic void back_to_idle(logic [7:0] lvl, logic on);
    if (ph == PHN_LEAVE) begin
      arm_timer(16'(cfg.blink_ms));
    end else begin
      timer_armed = 1'b0;
      led = lamp(on, lvl, COLOR_MAX, COLOR_MAX, COLOR_MAX);
      ph = PHN_IDLE;
    end
  endfunction

  function automatic logic [2:0] timer_fired(logic [7:0] lvl, logic on, logic jn);
    logic [2:0] act;
    logic       lit;
    act = ACT_NONE;
    timer_armed = 1'b0;
    case (ph)
      PHN_ARMED_2: begin
        ph = PHN_READY;
        led = lamp(1'b1, FULL_LEVEL, COLOR_MAX, COLOR_OFF, COLOR_OFF);
        arm_timer(cfg.ready_delay_ms >> 1);
      end
      PHN_READY: begin
        ph = PHN_LV_ON;
        blinks_left = cfg.blink_count;
        led = lamp(1'b0, FULL_LEVEL, COLOR_MAX, COLOR_OFF, COLOR_OFF);
        arm_timer(16'(cfg.blink_ms));
      end
      PHN_LV_ON, PHN_LV_OFF: begin
        if (blinks_left != 0) begin
          lit = (ph == PHN_LV_ON);
          ph = lit ? PHN_LV_OFF : PHN_LV_ON;
          blinks_left--;
          led = lamp(lit, FULL_LEVEL, COLOR_MAX, COLOR_OFF, COLOR_OFF);
          arm_timer(16'(cfg.blink_ms));
        end else begin
          ph = PHN_LEAVE;
          led = lamp(1'b1, FULL_LEVEL, COLOR_OFF, COLOR_MAX, COLOR_OFF);
          arm_timer({cfg.blink_ms, 1'b0});
        end
      end
      PHN_LEAVE: begin
        act = ACT_LEAVE;
        ph = PHN_IDLE;
        cool_left = {cfg.cooldown_ms, 1'b0};
        back_to_idle(lvl, on);
      end
      PHN_NS_OFF, PHN_NS_ON: begin
        if (blinks_left != 0) begin
          lit = (ph == PHN_NS_ON);
          ph = lit ? PHN_NS_OFF : PHN_NS_ON;
          blinks_left--;
          if (jn) begin
            led = lamp(lit, FULL_LEVEL, COLOR_OFF, COLOR_MAX, COLOR_OFF);
          end else begin
            led = lamp(lit, FULL_LEVEL, COLOR_MAX, COLOR_OFF, COLOR_OFF);
          end
          arm_timer(16'(cfg.blink_ms >> 2));
        end else begin
          back_to_idle(lvl, on);
          cool_left = 16'(cfg.cooldown_ms);
        end
      end
      default: back_to_idle(lvl, on);
    endcase
    return act;
  endfunction

  function automatic outcome_t next_outcome(cmd_t c, logic [7:0] lvl, logic on, logic jn);
    logic [2:0] act;
    act = ACT_NONE;
    case (c)
      CMD_TICK: begin
        if (cool_left != 0) cool_left--;
        if (timer_armed) begin
          if (timer_left <= 1) begin
            timer_left = '0;
            act = timer_fired(lvl, on, jn);
          end else begin
            timer_left--;
          end
        end
      end
      CMD_RELEASE: begin
        if (ph == PHN_IDLE) begin
          if (cool_left == 0) begin
            cool_left = 16'(cfg.cooldown_ms);
            act = ACT_TOGGLE;
          end
          back_to_idle(lvl, on);
        end else if (ph == PHN_ARMED_1) begin
          act = ACT_STATUS;
          ph = PHN_NS_OFF;
          blinks_left = cfg.blink_count;
          arm_timer(16'(cfg.blink_ms));
        end else begin
          if (ph == PHN_ARMED_2) act = ACT_BIND;
          back_to_idle(lvl, on);
        end
      end
      CMD_MEDIUM: begin
        if (ph == PHN_IDLE) begin
          ph = PHN_ARMED_1;
          led = lamp(1'b1, FULL_LEVEL, COLOR_OFF, COLOR_MAX, COLOR_OFF);
        end else begin
          back_to_idle(lvl, on);
        end
      end
      CMD_LONG: begin
        if (ph == PHN_ARMED_1) begin
          ph = PHN_ARMED_2;
          led = lamp(1'b1, FULL_LEVEL, COLOR_MAX, ORANGE_G, COLOR_OFF);
          arm_timer(cfg.ready_delay_ms);
        end else begin
          back_to_idle(lvl, on);
        end
      end
      default: ;
    endcase
    return {act, led, ph};
  endfunction

  always @(posedge clk) begin : score
    outcome_t got;
    outcome_t want;
    if (rst) begin
      cfg = '{COOLDOWN_RST, READY_DELAY_RST, BLINK_RST, BLINK_COUNT_RST};
      ph = PHN_IDLE;
      blinks_left = '0;
      timer_left = '0;
      timer_armed = 1'b0;
      cool_left = '0;
      led = '0;
      expected_outcomes.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          CFG_COOLDOWN:    cfg.cooldown_ms    = write_data[14:0];
          CFG_READY_DELAY: cfg.ready_delay_ms = write_data;
          CFG_BLINK:       cfg.blink_ms       = write_data[14:0];
          CFG_BLINK_COUNT: cfg.blink_count    = write_data[7:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = {res.action, res.led_enable, res.led_level, res.led_red, res.led_green,
               res.led_blue, res.phase_now};
        if (expected_outcomes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with no request outstanding: %p", $time, got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (evt.valid && evt.ready) begin
        expected_outcomes.push_back(next_outcome(evt.command, evt.light_level, evt.light_on,
                                                 evt.joined));
      end
    end
    n_pending <= expected_outcomes.size();
  end

endmodule

// ----- dv/tb_hall_hold_gesture_sequencer_core.sv -----
// Testbench top for the hall hold gesture sequencer: clock, reset, stimulus and verdict.
module tb_hall_hold_gesture_sequencer_core;
  import hhgs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  hhgs_in_if  evt ();
  hhgs_out_if res ();

  int   fail_count;
  int   n_pending;
  int   sent_count = 0;
  bit   calm = 1'b0;
  logic holdoff;
  int   cd_now, rd_now, bm_now, bc_now;

  always #6 clk = ~clk;

  hall_hold_gesture_sequencer_core uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .evt          (evt),
    .res          (res)
  );

  hhgs_checker chk (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .evt          (evt),
    .res          (res),
    .fail_count   (fail_count),
    .n_pending    (n_pending)
  );

  function automatic int span(int d);
    return (d == 0) ? 1 : d;
  endfunction

  task automatic offer(cmd_t c, logic [7:0] lvl, logic on, logic jn);
    if (!calm && (sent_count / 32) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    evt.valid       <= 1'b1;
    evt.command     <= c;
    evt.light_level <= lvl;
    evt.light_on    <= on;
    evt.joined      <= jn;
    do @(posedge clk); while (!evt.ready);
    sent_count++;
  endtask

  task automatic offer_rand(cmd_t c);
    offer(c, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic ticks(int n);
    repeat (n) offer_rand(CMD_TICK);
  endtask

  // only with no request outstanding
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    evt.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (2) @(posedge clk);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= val;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic load_settings(logic [15:0] cd, logic [15:0] rd, logic [15:0] bm,
                               logic [15:0] bc);
    write_reg(CFG_COOLDOWN, cd);
    write_reg(CFG_READY_DELAY, rd);
    write_reg(CFG_BLINK, bm);
    write_reg(CFG_BLINK_COUNT, bc);
    cd_now = int'(cd & 16'h7FFF);
    rd_now = int'(rd);
    bm_now = int'(bm & 16'h7FFF);
    bc_now = int'(bc & 16'h00FF);
  endtask

  // status and leave runs are sometimes broken off by a stray hold or release
  task automatic run_gesture();
    int kind;
    int n;
    int cut;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        if ($urandom_range(0, 1) == 1) ticks($urandom_range(0, cd_now + 1));
        offer_rand(CMD_RELEASE);
      end
      2, 3, 4, 5, 6: begin
        offer_rand(CMD_MEDIUM);
        if (kind < 4) begin
          offer_rand(CMD_RELEASE);
          n = span(bm_now) + bc_now * span(bm_now >> 2);
        end else begin
          offer_rand(CMD_LONG);
          n = span(rd_now) + span(rd_now / 2) + (bc_now + 1) * span(bm_now) + span(2 * bm_now);
        end
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(0, n);
          ticks(cut);
          offer_rand(cmd_t'(2'($urandom_range(1, 3))));
          ticks(n - cut + span(bm_now) + 1);
        end else begin
          ticks(n + $urandom_range(0, 2));
        end
      end
      7: begin
        offer_rand(CMD_MEDIUM);
        offer_rand(CMD_LONG);
        ticks($urandom_range(0, rd_now));
        offer_rand(CMD_RELEASE);
      end
      default: begin
        repeat ($urandom_range(1, 5)) offer_rand(cmd_t'(2'($urandom_range(0, 3))));
      end
    endcase
  endtask

  task automatic random_phase(int n_items);
    int start;
    load_settings(16'($urandom_range(0, 40)) | (16'h8000 & 16'($urandom)),
                  16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 9)) | (16'h8000 & 16'($urandom)),
                  16'($urandom_range(0, 5)) | (16'hFF00 & 16'($urandom)));
    start = sent_count;
    while (sent_count - start < n_items) run_gesture();
  endtask

  initial begin : rx_pace
    int unsigned gap;
    int unsigned beat;
    gap = 0;
    beat = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (gap != 0) begin
        gap--;
      end else if (!calm && (beat / 50) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
      end
      res.ready <= (gap == 0) && !holdoff;
    end
  end

  // long receiver hold-off so the result register backs up into the request side
  initial begin
    holdoff <= 1'b0;
    wait (sent_count >= 320);
    @(posedge clk);
    holdoff <= 1'b1;
    repeat (40) @(posedge clk);
    holdoff <= 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    write_enable    <= 1'b0;
    reg_index       <= CFG_COOLDOWN;
    write_data      <= '0;
    evt.valid       <= 1'b0;
    evt.command     <= CMD_TICK;
    evt.light_level <= '0;
    evt.light_on    <= 1'b0;
    evt.joined      <= 1'b0;
    cd_now = int'(COOLDOWN_RST);
    rd_now = int'(READY_DELAY_RST);
    bm_now = int'(BLINK_RST);
    bc_now = int'(BLINK_COUNT_RST);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every command, holds out of sequence, bind and status start
    offer(CMD_TICK, 8'h00, 1'b0, 1'b0);
    offer(CMD_MEDIUM, 8'hFF, 1'b1, 1'b1);
    offer(CMD_MEDIUM, 8'h80, 1'b1, 1'b0);
    offer(CMD_LONG, 8'h00, 1'b0, 1'b1);
    offer(CMD_MEDIUM, 8'h01, 1'b0, 1'b0);
    offer(CMD_LONG, 8'hFE, 1'b1, 1'b1);
    offer(CMD_TICK, 8'h7F, 1'b1, 1'b0);
    offer(CMD_RELEASE, 8'h5A, 1'b1, 1'b0);
    offer(CMD_MEDIUM, 8'hA5, 1'b0, 1'b1);
    offer(CMD_RELEASE, 8'h00, 1'b0, 1'b0);
    offer(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    offer(CMD_LONG, 8'h33, 1'b1, 1'b0);
    offer(CMD_MEDIUM, 8'hCC, 1'b0, 1'b1);
    offer(CMD_LONG, 8'h0F, 1'b1, 1'b1);
    offer(CMD_MEDIUM, 8'hF0, 1'b0, 1'b0);

    // light toggle and its cooldown
    load_settings(16'd3, 16'd1, 16'd4, 16'd1);
    offer(CMD_RELEASE, 8'hFF, 1'b1, 1'b0);
    offer(CMD_RELEASE, 8'h00, 1'b0, 1'b1);
    ticks(3);
    offer(CMD_RELEASE, 8'h96, 1'b1, 1'b1);

    // longest status blink, zero-length status delay
    load_settings(16'd5, 16'd1, 16'd0, 16'hAAFF);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_RELEASE);
    ticks(span(bm_now) + bc_now * span(bm_now >> 2) + 2);
    offer_rand(CMD_RELEASE);

    repeat (2) random_phase(30);

    calm = 1'b1;
    random_phase(40);

    // leave with largest cooldown, release during the green pause
    load_settings(16'h7FFF, 16'd2, 16'd4, 16'd1);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_LONG);
    ticks(13);
    offer_rand(CMD_RELEASE);
    ticks(5);
    offer_rand(CMD_RELEASE);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_RELEASE);
    ticks(6);

    // all registers at their maximum
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_rand(CMD_RELEASE);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_LONG);
    ticks(3);
    offer_rand(CMD_RELEASE);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_RELEASE);
    ticks(2);
    offer_rand(CMD_MEDIUM);
    offer_rand(CMD_LONG);
    offer_rand(CMD_TICK);

    evt.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
